>>> rtl/core/grid_neighbor_enumerator_assert.svh
// ----------------------------------------------------------------------------
// Grid neighbor enumerator assertion macros
// Shorthand for clocked, reset-qualified property checks on the block ports.
// ----------------------------------------------------------------------------
`ifndef GRID_NEIGHBOR_ENUMERATOR_ASSERT_SVH
`define GRID_NEIGHBOR_ENUMERATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GNE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("grid neighbor enumerator check failed");

// Consequent must hold in the cycle after the antecedent.
`define GNE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("grid neighbor enumerator check failed");

`endif

>>> rtl/core/gne_pkg.sv
// ----------------------------------------------------------------------------
// Grid neighbor enumerator package
// Shared widths, codes, beat types and state encodings.
// ----------------------------------------------------------------------------
package gne_pkg;

    localparam int CW       = 11;          // cell coordinate and count width
    localparam int BW       = CW + 2;      // signed width for clipped bounds
    localparam int IDX_W    = 20;          // linear index width
    localparam int FX_W     = 32;          // Q16.16 word width
    localparam int CFG_IW   = 3;           // register index width
    localparam int CELL_CAP = 2**CW - 1;   // largest count a register can hold

    localparam logic [1:0] MODE_XY    = 2'd0;
    localparam logic [1:0] MODE_INDEX = 2'd1;
    localparam logic [1:0] MODE_POINT = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;

    localparam logic [CFG_IW-1:0] CFG_CELLS_X  = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_CELLS_Y  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_ORIGIN_X = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_ORIGIN_Y = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_LIMIT_X  = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_LIMIT_Y  = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_SCALE    = 3'd6;

    typedef struct packed {
        logic [1:0]             mode;
        logic [9:0]             cell_x;
        logic [9:0]             cell_y;
        logic [IDX_W-1:0]       cell_index;
        logic signed [FX_W-1:0] point_x;
        logic signed [FX_W-1:0] point_y;
        logic [1:0]             steps;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] neighbor_index;
        logic [1:0]       status;
        logic             last;
    } t_out_item;

    // Grid settings as seen by the datapath, counts already saturated.
    typedef struct packed {
        logic [CW-1:0]          nx;
        logic [CW-1:0]          ny;
        logic signed [FX_W-1:0] origin_x;
        logic signed [FX_W-1:0] origin_y;
        logic signed [FX_W-1:0] limit_x;
        logic signed [FX_W-1:0] limit_y;
        logic [FX_W-1:0]        scale;
    } t_cfg;

    // Classified query handed from the front to the back.
    typedef struct packed {
        logic          err;
        logic [CW-1:0] cx;
        logic [CW-1:0] cy;
        logic [1:0]    steps;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [2:0] {
        F_IDLE,
        F_DECODE,
        F_DIV,
        F_MUL,
        F_CHK,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_BOUND,
        B_BASE,
        B_WALK,
        B_SINGLE
    } t_back_state;

endpackage

>>> rtl/core/gne_queue.sv
// ----------------------------------------------------------------------------
// Grid neighbor enumerator job queue
// Two-entry FIFO that decouples query classification from the cell walk.
// ----------------------------------------------------------------------------
module gne_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gne_pkg::t_job  i_job,
    input  logic           i_pop,
    output gne_pkg::t_job  o_job,
    output gne_pkg::t_qstat o_qstat
);
    import gne_pkg::*;

    localparam int Depth = 2;
    localparam int PtrW  = $clog2(Depth);

    t_job            r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [PtrW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PtrW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PtrW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PtrW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (PtrW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_job         = r_mem[r_rd_ptr];
    assign o_qstat.full  = (r_count == (PtrW+1)'(Depth));
    assign o_qstat.empty = (r_count == '0);

endmodule

>>> rtl/core/gne_front.sv
// ----------------------------------------------------------------------------
// Grid neighbor enumerator front end
// Accepts a query, resolves its center cell and queues a job for the walk.
// ----------------------------------------------------------------------------
module gne_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  gne_pkg::t_in_item i_in_data,
    input  gne_pkg::t_cfg     i_cfg,
    output logic              o_push,
    output gne_pkg::t_job     o_job,
    input  gne_pkg::t_qstat   i_qstat
);
    import gne_pkg::*;

    localparam int DivCntW = $clog2(IDX_W);

    t_front_state       r_state;
    t_front_state       n_state;
    t_in_item           r_item;
    t_job               r_job;
    logic [FX_W-1:0]    r_dx;
    logic [FX_W-1:0]    r_dy;
    logic [FX_W-1:0]    r_prod;
    logic               r_axis;
    logic [IDX_W-1:0]   r_div;
    logic [CW-1:0]      r_rem;
    logic [DivCntW-1:0] r_cnt;

    logic [2*CW-1:0]   area;
    logic              idx_bad;
    logic              pt_bad;
    logic [FX_W:0]     dx_full;
    logic [FX_W:0]     dy_full;
    logic [FX_W-1:0]   mul_a;
    logic [2*FX_W-1:0] prod_full;
    logic [CW-1:0]     chk_lim;
    logic              chk_bad;
    logic [CW:0]       trial;
    logic              trial_ge;
    logic [CW:0]       trial_sub;
    logic [CW-1:0]     n_rem;

    // Query classification on the registered item.
    always_comb begin
        area    = i_cfg.nx * i_cfg.ny;
        idx_bad = {{(2*CW-IDX_W){1'b0}}, r_item.cell_index} >= area;
        pt_bad  = !(($signed(r_item.point_x) >= $signed(i_cfg.origin_x)) &&
                    ($signed(r_item.point_x) <  $signed(i_cfg.limit_x)) &&
                    ($signed(r_item.point_y) >= $signed(i_cfg.origin_y)) &&
                    ($signed(r_item.point_y) <  $signed(i_cfg.limit_y)));
        dx_full = {r_item.point_x[FX_W-1], r_item.point_x} -
                  {i_cfg.origin_x[FX_W-1], i_cfg.origin_x};
        dy_full = {r_item.point_y[FX_W-1], r_item.point_y} -
                  {i_cfg.origin_y[FX_W-1], i_cfg.origin_y};
    end

    // One shared multiplier, x axis first and then y axis.
    always_comb begin
        mul_a     = r_axis ? r_dy : r_dx;
        prod_full = mul_a * i_cfg.scale;
        chk_lim   = r_axis ? i_cfg.ny : i_cfg.nx;
        chk_bad   = r_prod >= {{(FX_W-CW){1'b0}}, chk_lim};
    end

    // Restoring divider step: one quotient bit of index / nx per cycle.
    always_comb begin
        trial     = {r_rem, r_div[IDX_W-1]};
        trial_ge  = trial >= {1'b0, i_cfg.nx};
        trial_sub = trial - {1'b0, i_cfg.nx};
        n_rem     = trial_ge ? trial_sub[CW-1:0] : trial[CW-1:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (i_in_valid) begin
                    n_state = F_DECODE;
                end
            end
            F_DECODE: begin
                unique case (r_item.mode)
                    MODE_XY:    n_state = F_PUSH;
                    MODE_INDEX: n_state = idx_bad ? F_PUSH : F_DIV;
                    MODE_POINT: n_state = pt_bad ? F_PUSH : F_MUL;
                    default:    n_state = F_PUSH;
                endcase
            end
            F_DIV: begin
                if (r_cnt == '0) begin
                    n_state = F_PUSH;
                end
            end
            F_MUL: n_state = F_CHK;
            F_CHK: begin
                if (chk_bad || r_axis) begin
                    n_state = F_PUSH;
                end else begin
                    n_state = F_MUL;
                end
            end
            F_PUSH: begin
                if (!i_qstat.full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != F_IDLE);
        o_push     = (r_state == F_PUSH) && !i_qstat.full;
        o_job      = r_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_axis  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                F_DECODE: begin
                    r_axis <= 1'b0;
                    r_cnt  <= DivCntW'(IDX_W - 1);
                end
                F_DIV:   r_cnt <= r_cnt - DivCntW'(1);
                F_CHK:   r_axis <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            F_IDLE: begin
                if (i_in_valid) begin
                    r_item <= i_in_data;
                end
            end
            F_DECODE: begin
                r_job.steps <= r_item.steps;
                r_job.cx    <= {1'b0, r_item.cell_x};
                r_job.cy    <= {1'b0, r_item.cell_y};
                r_div       <= r_item.cell_index;
                r_rem       <= '0;
                r_dx        <= dx_full[FX_W-1:0];
                r_dy        <= dy_full[FX_W-1:0];
                unique case (r_item.mode)
                    MODE_XY:    r_job.err <= 1'b0;
                    MODE_INDEX: r_job.err <= idx_bad;
                    MODE_POINT: r_job.err <= pt_bad;
                    default:    r_job.err <= 1'b1;
                endcase
            end
            F_DIV: begin
                r_rem <= n_rem;
                r_div <= {r_div[IDX_W-2:0], trial_ge};
                if (r_cnt == '0) begin
                    r_job.cx <= n_rem;
                    r_job.cy <= {r_div[CW-2:0], trial_ge};
                end
            end
            F_MUL: r_prod <= prod_full[2*FX_W-1:FX_W];
            F_CHK: begin
                if (chk_bad) begin
                    r_job.err <= 1'b1;
                end else if (r_axis) begin
                    r_job.cy <= r_prod[CW-1:0];
                end else begin
                    r_job.cx <= r_prod[CW-1:0];
                end
            end
            default: ;
        endcase
    end

endmodule

>>> rtl/core/gne_back.sv
// ----------------------------------------------------------------------------
// Grid neighbor enumerator back end
// Clips the neighborhood to the grid and walks it, one beat per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module gne_back #(
    parameter int MAX_STEPS = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gne_pkg::t_qstat    i_qstat,
    output logic               o_pop,
    input  gne_pkg::t_job      i_job,
    input  gne_pkg::t_cfg      i_cfg,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gne_pkg::t_out_item o_out_data
);
    import gne_pkg::*;

    localparam logic [1:0] StepCap = 2'(MAX_STEPS);

    t_back_state      r_state;
    t_back_state      n_state;
    t_job             r_job;
    logic [1:0]       r_status;
    logic signed [BW-1:0] r_xlo;
    logic signed [BW-1:0] r_xhi;
    logic signed [BW-1:0] r_ylo;
    logic signed [BW-1:0] r_yhi;
    logic [CW-1:0]    r_rx;
    logic [CW-1:0]    r_ry;
    logic [IDX_W-1:0] r_base;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [1:0]           s;
    logic signed [BW-1:0] s_s;
    logic signed [BW-1:0] cx_s;
    logic signed [BW-1:0] cy_s;
    logic signed [BW-1:0] nx_m1;
    logic signed [BW-1:0] ny_m1;
    logic signed [BW-1:0] xlo_raw;
    logic signed [BW-1:0] xhi_raw;
    logic signed [BW-1:0] ylo_raw;
    logic signed [BW-1:0] yhi_raw;
    logic                 empty;
    logic [2*CW-1:0]      base_full;
    logic                 out_free;
    logic                 is_center;
    logic                 row_end;
    logic                 at_end;
    logic [CW-1:0]        nrx;
    logic [CW-1:0]        nry;
    logic                 fin_center;
    logic                 last;
    logic                 go;
    logic                 emit;
    t_out_item            beat;

    // Neighborhood bounds, clipped to the grid.
    always_comb begin
        s       = (r_job.steps > StepCap) ? StepCap : r_job.steps;
        s_s     = $signed({{CW{1'b0}}, s});
        cx_s    = $signed({2'b00, r_job.cx});
        cy_s    = $signed({2'b00, r_job.cy});
        nx_m1   = $signed({2'b00, i_cfg.nx}) - BW'(1);
        ny_m1   = $signed({2'b00, i_cfg.ny}) - BW'(1);
        xlo_raw = cx_s - s_s;
        xhi_raw = cx_s + s_s;
        ylo_raw = cy_s - s_s;
        yhi_raw = cy_s + s_s;
    end

    // Nothing to emit when the window is empty or holds only the center.
    always_comb begin
        empty = (r_xlo > r_xhi) || (r_ylo > r_yhi) ||
                ((r_xlo == r_xhi) && (r_ylo == r_yhi) &&
                 (r_xlo == cx_s) && (r_ylo == cy_s));
        base_full = r_ylo[CW-1:0] * i_cfg.nx;
    end

    // Walk bookkeeping: the last beat is either the window corner or the
    // cell just before a center that sits in the corner.
    always_comb begin
        out_free   = !r_out_valid || !i_out_stall;
        is_center  = (r_rx == r_job.cx) && (r_ry == r_job.cy);
        row_end    = (r_rx == r_xhi[CW-1:0]);
        at_end     = row_end && (r_ry == r_yhi[CW-1:0]);
        nrx        = row_end ? r_xlo[CW-1:0] : r_rx + CW'(1);
        nry        = row_end ? r_ry + CW'(1) : r_ry;
        fin_center = (nrx == r_xhi[CW-1:0]) && (nry == r_yhi[CW-1:0]) &&
                     (r_xhi == cx_s) && (r_yhi == cy_s);
        last       = at_end || fin_center;
        go         = out_free || is_center;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_qstat.empty) begin
                    n_state = i_job.err ? B_SINGLE : B_BOUND;
                end
            end
            B_BOUND: n_state = B_BASE;
            B_BASE:  n_state = empty ? B_SINGLE : B_WALK;
            B_WALK: begin
                if (go && last && !is_center) begin
                    n_state = B_IDLE;
                end
            end
            B_SINGLE: begin
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop = (r_state == B_IDLE) && !i_qstat.empty;
        emit  = 1'b0;
        beat  = '0;
        unique case (r_state)
            B_WALK: begin
                emit                = out_free && !is_center;
                beat.neighbor_index = r_base + IDX_W'(r_rx);
                beat.status         = ST_OK;
                beat.last           = last;
            end
            B_SINGLE: begin
                emit        = out_free;
                beat.status = r_status;
                beat.last   = 1'b1;
            end
            default: ;
        endcase
        o_out_valid = r_out_valid;
        o_out_data  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= beat;
        end
        unique case (r_state)
            B_IDLE: begin
                r_job    <= i_job;
                r_status <= ST_RANGE;
            end
            B_BOUND: begin
                r_xlo <= (xlo_raw < 0) ? '0 : xlo_raw;
                r_ylo <= (ylo_raw < 0) ? '0 : ylo_raw;
                r_xhi <= (xhi_raw > nx_m1) ? nx_m1 : xhi_raw;
                r_yhi <= (yhi_raw > ny_m1) ? ny_m1 : yhi_raw;
            end
            B_BASE: begin
                r_status <= ST_NONE;
                r_rx     <= r_xlo[CW-1:0];
                r_ry     <= r_ylo[CW-1:0];
                r_base   <= base_full[IDX_W-1:0];
            end
            B_WALK: begin
                if (go) begin
                    r_rx <= nrx;
                    r_ry <= nry;
                    if (row_end) begin
                        r_base <= r_base + IDX_W'(i_cfg.nx);
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

>>> rtl/core/grid_neighbor_enumerator.sv
// ----------------------------------------------------------------------------
// Grid neighbor enumerator
// Lists the row-major indices of the cells around a query cell on a grid.
// ----------------------------------------------------------------------------
// A query beat enters on i_in_valid/o_in_stall and names a center cell as a
// column/row pair, a linear index or a Q16.16 point. For each query the block
// sends, on o_out_valid/i_out_stall, one beat per grid cell of the square of
// half width steps around the center, lowest row and column first, with the
// center left out; last marks the final beat. A bad query yields one beat with
// status out of range, an empty window one beat with status no neighbors.
// A column/row query is pushed as it stands, a linear index goes through the
// 20-step divider and a point takes up to two passes through the shared
// 32x32 multiplier. The walk then gives one beat a cycle while the receiver
// does not stall, passing the center without a beat; the two-entry job queue
// lets the front resolve the next query while the back walks the last one.
// While the receiver stalls, the output register holds its beat and the walk
// waits. Configuration writes on i_cfg_valid and o_cfg_ready are always taken
// and belong in idle time only. Reset restores the default 1024 by 1024 grid
// and empties both ends.
// ----------------------------------------------------------------------------
module grid_neighbor_enumerator #(
    parameter int MAX_STEPS          = 3,
    parameter int MAX_CELLS_PER_AXIS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  gne_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output gne_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gne_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [gne_pkg::FX_W-1:0]      i_cfg_data
);
    import gne_pkg::*;

    // Cell counts above the supported axis size are clamped to it.
    localparam int            SatCells = (MAX_CELLS_PER_AXIS > CELL_CAP) ?
                                         CELL_CAP : MAX_CELLS_PER_AXIS;
    localparam logic [CW-1:0] SatN     = CW'(SatCells);

    logic [CW-1:0]          r_cells_x;
    logic [CW-1:0]          r_cells_y;
    logic signed [FX_W-1:0] r_origin_x;
    logic signed [FX_W-1:0] r_origin_y;
    logic signed [FX_W-1:0] r_limit_x;
    logic signed [FX_W-1:0] r_limit_y;
    logic [FX_W-1:0]        r_scale;

    t_cfg   cfg;
    logic   push;
    logic   pop;
    t_job   front_job;
    t_job   queue_job;
    t_qstat qstat;

    // The register file never holds off a write.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_x  <= CW'(1024);
            r_cells_y  <= CW'(1024);
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_limit_x  <= 32'sh0400_0000;
            r_limit_y  <= 32'sh0400_0000;
            r_scale    <= 32'h0010_0000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CELLS_X:  r_cells_x  <= i_cfg_data[CW-1:0];
                CFG_CELLS_Y:  r_cells_y  <= i_cfg_data[CW-1:0];
                CFG_ORIGIN_X: r_origin_x <= i_cfg_data;
                CFG_ORIGIN_Y: r_origin_y <= i_cfg_data;
                CFG_LIMIT_X:  r_limit_x  <= i_cfg_data;
                CFG_LIMIT_Y:  r_limit_y  <= i_cfg_data;
                CFG_SCALE:    r_scale    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.nx       = (r_cells_x > SatN) ? SatN : r_cells_x;
        cfg.ny       = (r_cells_y > SatN) ? SatN : r_cells_y;
        cfg.origin_x = r_origin_x;
        cfg.origin_y = r_origin_y;
        cfg.limit_x  = r_limit_x;
        cfg.limit_y  = r_limit_y;
        cfg.scale    = r_scale;
    end

    // The front resolves the center cell; errors travel as flagged jobs.
    gne_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_cfg      (cfg),
        .o_push     (push),
        .o_job      (front_job),
        .i_qstat    (qstat)
    );

    gne_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_qstat (qstat)
    );

    // The back walks the clipped window and owns the output register.
    gne_back #(
        .MAX_STEPS (MAX_STEPS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .i_job       (queue_job),
        .i_cfg       (cfg),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> rtl/core/gne_check.sv
// ----------------------------------------------------------------------------
// Grid neighbor enumerator port checker
// Port-level properties of the enumerator, bound to the top level.
// ----------------------------------------------------------------------------
`include "grid_neighbor_enumerator_assert.svh"

module gne_check (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input gne_pkg::t_in_item          i_in_data,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input gne_pkg::t_out_item         o_out_data,
    input logic                       i_cfg_valid,
    input logic                       o_cfg_ready,
    input logic [gne_pkg::CFG_IW-1:0] i_cfg_index,
    input logic [gne_pkg::FX_W-1:0]   i_cfg_data
);
    import gne_pkg::*;

    // An error or empty-window beat always marks the end of its query.
    `GNE_ASSERT_NOW(a_status_ends_query, o_out_valid && o_out_data.status != ST_OK, o_out_data.last)

    // Status-only beats carry a zero index.
    `GNE_ASSERT_NOW(a_status_zero_index, o_out_valid && o_out_data.status != ST_OK, o_out_data.neighbor_index == '0)

    // The front takes one query at a time and is busy right after a beat.
    `GNE_ASSERT_NEXT(a_front_busy, i_in_valid && !o_in_stall, o_in_stall)

    // A stalled result beat stays put.
    `GNE_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

endmodule

bind grid_neighbor_enumerator gne_check u_gne_check (.*);
